[src/strm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_pkg
// Shared widths, codes, types and helpers of the range-maximum tree engine.
// ----------------------------------------------------------------------------
package strm_pkg;

    localparam int DATA_W          = 32;
    localparam int POS_W           = 11;
    localparam int CNT_W           = 11;
    localparam int DEF_LEAF_COUNT  = 1024;

    localparam logic [CNT_W-1:0]         RESET_ELEMENT_COUNT = 11'd1024;
    localparam logic signed [DATA_W-1:0] FILL_VALUE          = -(32'sd1 <<< 30);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // memory port enables from the sequencer
    typedef struct packed {
        logic we;
        logic re_a;
        logic re_b;
    } ram_ctl_t;

    // finished query handed to the output register
    typedef struct packed {
        logic                     load;
        logic                     bad;
        logic signed [DATA_W-1:0] max_value;
    } result_t;

    function automatic logic signed [DATA_W-1:0] max_val(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

[src/segment_tree_range_max_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_max_unit
// Max segment tree over signed 32-bit values: point writes, range-max queries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | in        | in_valid / in_stall   | mode, position, value, range_low, range_high
//  out     | out       | out_valid / out_stall | max_value, bad_range
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data (element_count)
//
//  A write walks from leaf to root, one node per cycle, set by the single
//  write port of the node memory. A query walks one tree level per cycle on
//  the two read ports, then drains the registered read data; a flagged
//  query skips the walk and a dropped write leaves the sequencer idle.
//  After reset a clearing pass over all 2*LEAF_COUNT nodes holds in_stall
//  high; cfg writes are taken.
//  A result waits in the output register under out_stall; the next item is
//  taken meanwhile, and a later query holds before loading until it leaves.
// ----------------------------------------------------------------------------
module segment_tree_range_max_unit #(
    parameter int LEAF_COUNT = strm_pkg::DEF_LEAF_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mode,
    input  logic [strm_pkg::POS_W-1:0]         position,
    input  logic signed [strm_pkg::DATA_W-1:0] value,
    input  logic [strm_pkg::POS_W-1:0]         range_low,
    input  logic [strm_pkg::POS_W-1:0]         range_high,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [strm_pkg::DATA_W-1:0] max_value,
    output logic                               bad_range,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [strm_pkg::CNT_W-1:0]         cfg_data
);

    import strm_pkg::*;

    localparam int NODE_W = $clog2(2 * LEAF_COUNT);

    logic [CNT_W-1:0]         element_count_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] max_value_reg;
    logic                     bad_range_reg;

    logic                     in_accept, busy, out_free;
    ram_ctl_t                 ram_ctl;
    result_t                  result;
    logic [NODE_W-1:0]        waddr, raddr_a, raddr_b;
    logic signed [DATA_W-1:0] wdata, rdata_a, rdata_b;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign max_value = max_value_reg;
    assign bad_range = bad_range_reg;

    strm_ctrl #(
        .LEAF_COUNT (LEAF_COUNT)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_accept     (in_accept),
        .mode          (mode),
        .position      (position),
        .value         (value),
        .range_low     (range_low),
        .range_high    (range_high),
        .element_count (element_count_reg),
        .out_free      (out_free),
        .busy          (busy),
        .ram_ctl       (ram_ctl),
        .waddr         (waddr),
        .wdata         (wdata),
        .raddr_a       (raddr_a),
        .raddr_b       (raddr_b),
        .rdata_a       (rdata_a),
        .rdata_b       (rdata_b),
        .result        (result)
    );

    strm_node_ram #(
        .DEPTH (2 * LEAF_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .ram_ctl (ram_ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= RESET_ELEMENT_COUNT;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                element_count_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.load)
        begin
            max_value_reg <= result.max_value;
            bad_range_reg <= result.bad;
        end
    end

endmodule

[src/strm_node_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_node_ram
// Node store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module strm_node_ram #(
    parameter int  DEPTH  = 2 * strm_pkg::DEF_LEAF_COUNT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  strm_pkg::ram_ctl_t         ram_ctl,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [strm_pkg::DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr_a,
    input  logic [ADDR_W-1:0]          raddr_b,
    output logic [strm_pkg::DATA_W-1:0] rdata_a,
    output logic [strm_pkg::DATA_W-1:0] rdata_b
);

    logic [strm_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ram_ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ram_ctl.re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (ram_ctl.re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

[src/strm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_ctrl
// Sequencer for the tree: clearing pass, leaf-to-root update, query walk.
// ----------------------------------------------------------------------------
module strm_ctrl #(
    parameter int  LEAF_COUNT = strm_pkg::DEF_LEAF_COUNT,
    localparam int NODE_W     = $clog2(2 * LEAF_COUNT)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_accept,
    input  logic                               mode,
    input  logic [strm_pkg::POS_W-1:0]         position,
    input  logic signed [strm_pkg::DATA_W-1:0] value,
    input  logic [strm_pkg::POS_W-1:0]         range_low,
    input  logic [strm_pkg::POS_W-1:0]         range_high,
    input  logic [strm_pkg::CNT_W-1:0]         element_count,
    input  logic                               out_free,
    output logic                               busy,
    output strm_pkg::ram_ctl_t                 ram_ctl,
    output logic [NODE_W-1:0]                  waddr,
    output logic signed [strm_pkg::DATA_W-1:0] wdata,
    output logic [NODE_W-1:0]                  raddr_a,
    output logic [NODE_W-1:0]                  raddr_b,
    input  logic signed [strm_pkg::DATA_W-1:0] rdata_a,
    input  logic signed [strm_pkg::DATA_W-1:0] rdata_b,
    output strm_pkg::result_t                  result
);

    import strm_pkg::*;

    localparam int IDX_W = (NODE_W + 1 > POS_W) ? NODE_W + 1 : POS_W;
    localparam logic [IDX_W-1:0]  L_IDX     = IDX_W'(LEAF_COUNT);
    localparam logic [IDX_W-1:0]  IDX_ONE   = IDX_W'(1);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(2 * LEAF_COUNT - 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_WLEAF  = 6'b000100,
        S_WUP    = 6'b001000,
        S_QWALK  = 6'b010000,
        S_QDRAIN = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [NODE_W-1:0]        clear_cnt_reg, clear_cnt_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         right_reg, right_next;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    logic signed [DATA_W-1:0] best_reg, best_next;
    logic signed [DATA_W-1:0] pair_reg, pair_next;
    logic                     bad_reg, bad_next;
    logic                     va_reg, va_next;
    logic                     vb_reg, vb_next;

    logic [IDX_W-1:0]         pos_ext, lo_ext, hi_ext, ec_ext, limit;
    logic                     pos_ok, query_bad;
    logic [IDX_W-1:0]         sib_idx, parent_idx, parent_sib, right_dec, left_step;
    logic signed [DATA_W-1:0] up_max;

    assign pos_ext    = IDX_W'(position);
    assign lo_ext     = IDX_W'(range_low);
    assign hi_ext     = IDX_W'(range_high);
    assign ec_ext     = IDX_W'(element_count);
    assign limit      = (ec_ext > L_IDX) ? L_IDX : ec_ext;
    assign pos_ok     = (pos_ext != '0) && (pos_ext <= L_IDX);
    assign query_bad  = (lo_ext == '0) || (lo_ext > hi_ext) || (hi_ext > limit);

    assign sib_idx    = idx_reg ^ IDX_ONE;
    assign parent_idx = idx_reg >> 1;
    assign parent_sib = parent_idx ^ IDX_ONE;
    assign right_dec  = right_reg - IDX_ONE;
    assign left_step  = (idx_reg + IDX_W'(idx_reg[0])) >> 1;
    assign up_max     = max_val(cur_reg, rdata_a);

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        idx_next       = idx_reg;
        right_next     = right_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        bad_next       = bad_reg;
        va_next        = 1'b0;
        vb_next        = 1'b0;
        pair_next      = max_val(va_reg ? rdata_a : FILL_VALUE,
                                 vb_reg ? rdata_b : FILL_VALUE);
        ram_ctl        = '0;
        waddr          = idx_reg[NODE_W-1:0];
        wdata          = cur_reg;
        raddr_a        = idx_reg[NODE_W-1:0];
        raddr_b        = right_dec[NODE_W-1:0];
        result.load    = 1'b0;
        result.bad     = bad_reg;
        result.max_value = FILL_VALUE;

        case (state_reg)
            S_CLEAR:
            begin
                ram_ctl.we     = 1'b1;
                waddr          = clear_cnt_reg;
                wdata          = FILL_VALUE;
                clear_cnt_next = clear_cnt_reg + NODE_W'(1);
                if (clear_cnt_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode == MODE_WRITE)
                    begin
                        idx_next = L_IDX + pos_ext - IDX_ONE;
                        cur_next = value;
                        // drop writes to positions outside the tree
                        if (pos_ok)
                        begin
                            state_next = S_WLEAF;
                        end
                    end
                    else
                    begin
                        idx_next   = L_IDX + lo_ext - IDX_ONE;
                        right_next = L_IDX + hi_ext;
                        best_next  = FILL_VALUE;
                        bad_next   = query_bad;
                        state_next = query_bad ? S_QDRAIN : S_QWALK;
                    end
                end
            end
            S_WLEAF:
            begin
                ram_ctl.we   = 1'b1;
                ram_ctl.re_a = 1'b1;
                raddr_a      = sib_idx[NODE_W-1:0];
                state_next   = S_WUP;
            end
            S_WUP:
            begin
                ram_ctl.we = 1'b1;
                waddr      = parent_idx[NODE_W-1:0];
                wdata      = up_max;
                cur_next   = up_max;
                idx_next   = parent_idx;
                if (parent_idx == IDX_ONE)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_ctl.re_a = 1'b1;
                    raddr_a      = parent_sib[NODE_W-1:0];
                end
            end
            S_QWALK:
            begin
                best_next = max_val(best_reg, pair_reg);
                if (idx_reg < right_reg)
                begin
                    ram_ctl.re_a = idx_reg[0];
                    ram_ctl.re_b = right_reg[0];
                    va_next      = idx_reg[0];
                    vb_next      = right_reg[0];
                    idx_next     = left_step;
                    right_next   = right_reg >> 1;
                end
                else
                begin
                    state_next = S_QDRAIN;
                end
            end
            S_QDRAIN:
            begin
                // last pair lands in best this cycle; hold while the slot is full
                best_next        = max_val(best_reg, pair_reg);
                result.max_value = bad_reg ? FILL_VALUE : best_next;
                if (out_free)
                begin
                    result.load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            va_reg        <= va_next;
            vb_reg        <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        right_reg <= right_next;
        cur_reg   <= cur_next;
        best_reg  <= best_next;
        pair_reg  <= pair_next;
        bad_reg   <= bad_next;
    end

    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_ctl.we && ram_ctl.re_a) |-> (waddr != raddr_a))
        else $error("read and write of the same node in one cycle");

    a_drained_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        result.load |-> (!va_reg && !vb_reg))
        else $error("query result loaded with reads still in flight");

    a_leaf_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WLEAF) |-> (idx_reg >= L_IDX))
        else $error("leaf write below the leaf row");

    a_best_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QDRAIN) |-> (best_reg >= FILL_VALUE))
        else $error("running maximum fell below the fill value");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the range-maximum tree engine. A directed table
// covers reset contents, extreme values, dropped writes and flagged ranges.
// Random writes and queries follow under several element counts and idle
// patterns. Query results are checked against a local max-tree model or, for typed directed rows, the table.
// ----------------------------------------------------------------------------
module tb;

    import strm_pkg::*;

    localparam int LEAVES      = DEF_LEAF_COUNT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 30;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic                     bad;
    } range_result_t;

    typedef struct {
        logic                     mode;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0]         lo;
        logic [POS_W-1:0]         hi;
        bit                       typed;
        range_result_t            want;
    } stim_row_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic                     mode       = MODE_WRITE;
    logic [POS_W-1:0]         position   = '0;
    logic signed [DATA_W-1:0] value      = '0;
    logic [POS_W-1:0]         range_low  = '0;
    logic [POS_W-1:0]         range_high = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic signed [DATA_W-1:0] max_value;
    logic                     bad_range;
    logic                     cfg_valid  = 1'b0;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         cfg_data   = '0;

    // local copy of the tree and the register
    logic signed [DATA_W-1:0] node_max [2*LEAVES];
    logic [CNT_W-1:0]         elem_count;

    range_result_t pending_maxima[$];
    stim_row_t     directed_rows[$];
    stim_row_t     cur_row;
    int            sender_idle_pct    = 0;
    int            receiver_stall_pct = 0;
    bit            hold_request       = 1'b0;
    int            hold_left          = 0;
    int            mismatch_count     = 0;
    int            cycle_count        = 0;

    segment_tree_range_max_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .position   (position),
        .value      (value),
        .range_low  (range_low),
        .range_high (range_high),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .max_value  (max_value),
        .bad_range  (bad_range),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic signed [DATA_W-1:0] larger(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic void tree_store(input logic [POS_W-1:0] pos,
                                       input logic signed [DATA_W-1:0] val);
        int idx;
        if (pos == 0 || pos > LEAVES)
            return;
        idx = LEAVES + pos - 1;
        node_max[idx] = val;
        while (idx > 1)
        begin
            idx = idx >> 1;
            node_max[idx] = larger(node_max[2*idx], node_max[2*idx+1]);
        end
    endfunction

    function automatic range_result_t tree_range_max(input logic [POS_W-1:0] lo,
                                                     input logic [POS_W-1:0] hi);
        range_result_t r;
        int limit;
        int left;
        int right;
        limit = (elem_count > LEAVES) ? LEAVES : elem_count;
        r.max_value = FILL_VALUE;
        r.bad = (lo == 0) || (lo > hi) || (hi > limit);
        if (!r.bad)
        begin
            // half-open walk over leaf indices
            left  = LEAVES + lo - 1;
            right = LEAVES + hi;
            while (left < right)
            begin
                if (left & 1)
                begin
                    r.max_value = larger(r.max_value, node_max[left]);
                    left++;
                end
                if (right & 1)
                begin
                    right--;
                    r.max_value = larger(r.max_value, node_max[right]);
                end
                left  = left >> 1;
                right = right >> 1;
            end
        end
        return r;
    endfunction

    function automatic void add_row(input logic mode_i, input int pos, input int val,
                                    input int lo, input int hi, input bit typed,
                                    input int want_max, input bit want_bad);
        stim_row_t r;
        r.mode           = mode_i;
        r.pos            = POS_W'(pos);
        r.val            = val;
        r.lo             = POS_W'(lo);
        r.hi             = POS_W'(hi);
        r.typed          = typed;
        r.want.max_value = want_max;
        r.want.bad       = want_bad;
        directed_rows.push_back(r);
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t r;
        int lim;
        int pick;
        int span;
        lim     = (elem_count > LEAVES) ? LEAVES : elem_count;
        pick    = $urandom_range(0, 99);
        r.typed = 1'b0;
        r.want  = '0;
        r.val   = $urandom;
        r.pos   = POS_W'($urandom_range(0, 2047));
        r.lo    = POS_W'($urandom_range(0, 2047));
        r.hi    = POS_W'($urandom_range(0, 2047));
        if (pick < 45)
        begin
            r.mode = MODE_WRITE;
            // keep most writes inside the range that queries can see
            if (pick < 30 && lim > 0)
                r.pos = POS_W'($urandom_range(1, lim));
            else if (pick < 42)
                r.pos = POS_W'($urandom_range(1, LEAVES));
        end
        else if (pick < 90 && lim > 0)
        begin
            r.mode = MODE_QUERY;
            r.lo   = POS_W'($urandom_range(1, lim));
            span   = $urandom_range(0, 3);
            if (pick < 60)
                r.hi = (int'(r.lo) + span > lim) ? POS_W'(lim) : POS_W'(int'(r.lo) + span);
            else
                r.hi = POS_W'($urandom_range(r.lo, lim));
        end
        else
            r.mode = MODE_QUERY;
        return r;
    endfunction

    task automatic send_row(input stim_row_t r);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cur_row    = r;
        in_valid   <= 1'b1;
        mode       <= r.mode;
        position   <= r.pos;
        value      <= r.val;
        range_low  <= r.lo;
        range_high <= r.hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_element_count(input logic [CNT_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let the last query drain and any trailing write finish its tree walk
    task automatic wait_drained();
        while (pending_maxima.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        range_result_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cfg_valid && cfg_ready)
                elem_count = cfg_data;
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_WRITE)
                    tree_store(position, value);
                else
                begin
                    want = tree_range_max(range_low, range_high);
                    if (cur_row.typed)
                        want = cur_row.want;
                    pending_maxima.push_back(want);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (pending_maxima.size() == 0)
                begin
                    $error("result with no query pending: max_value %0d bad_range %0b",
                           max_value, bad_range);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_maxima.pop_front();
                    if (max_value !== want.max_value)
                    begin
                        $error("max_value: expected %0d, got %0d", want.max_value, max_value);
                        mismatch_count++;
                    end
                    if (bad_range !== want.bad)
                    begin
                        $error("bad_range: expected %0b, got %0b", want.bad, bad_range);
                        mismatch_count++;
                    end
                end
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        int n;
        logic [CNT_W-1:0] phase_count [5];
        int phase_items [5];
        int phase_tx_idle [5];
        int phase_rx_stall [5];

        for (int i = 0; i < 2*LEAVES; i++)
            node_max[i] = FILL_VALUE;
        elem_count = RESET_ELEMENT_COUNT;

        // reset contents, flagged ranges
        add_row(MODE_QUERY, 0, 0, 1, 1024, 1, FILL_VALUE, 0);
        add_row(MODE_QUERY, 0, 0, 0, 5, 1, FILL_VALUE, 1);
        add_row(MODE_QUERY, 0, 0, 5, 4, 1, FILL_VALUE, 1);
        add_row(MODE_QUERY, 0, 0, 1, 1025, 1, FILL_VALUE, 1);
        add_row(MODE_QUERY, 2047, -1, 2047, 2047, 1, FILL_VALUE, 1);
        // dropped writes: position 0 and beyond the leaves
        add_row(MODE_WRITE, 0, 123, 0, 0, 0, 0, 0);
        add_row(MODE_WRITE, 1025, 456, 0, 0, 0, 0, 0);
        add_row(MODE_WRITE, 2047, 32'h7fffffff, 2047, 2047, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 1, 1024, 1, FILL_VALUE, 0);
        // value extremes at the end leaves; the most negative one stays under the fill
        add_row(MODE_WRITE, 1, 32'h7fffffff, 0, 0, 0, 0, 0);
        add_row(MODE_WRITE, 1024, 32'h80000000, 0, 0, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 1, 1024, 1, 32'h7fffffff, 0);
        add_row(MODE_QUERY, 0, 0, 1024, 1024, 1, FILL_VALUE, 0);
        add_row(MODE_QUERY, 0, 0, 1, 1, 1, 32'h7fffffff, 0);
        // interior values, unwritten stretches
        add_row(MODE_WRITE, 512, -5, 0, 0, 0, 0, 0);
        add_row(MODE_WRITE, 513, 7, 0, 0, 0, 0, 0);
        add_row(MODE_WRITE, 300, -1, 0, 0, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 2, 1023, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 2, 511, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 514, 1023, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 1000, 1024, 0, 0, 0);
        // overwrite below the fill value
        add_row(MODE_WRITE, 1, 32'hbfffffff, 0, 0, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 1, 1, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 1, 511, 0, 0, 0);

        phase_count    = '{11'd2047, 11'($urandom_range(2, 1023)), 11'd1024, 11'd1, 11'd0};
        phase_items    = '{320, 320, 320, 120, 60};
        phase_tx_idle  = '{14, 55, 0, 0, 0};
        phase_rx_stall = '{55, 14, 0, 0, 0};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_row(directed_rows[i]);
        in_valid <= 1'b0;

        for (phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            write_element_count(phase_count[phase]);
            sender_idle_pct    = phase_tx_idle[phase];
            receiver_stall_pct = phase_rx_stall[phase];
            // fill the block up against a long receiver hold
            if (phase == 2)
                hold_request = 1'b1;
            for (n = 0; n < phase_items[phase]; n++)
                send_row(random_row());
            in_valid <= 1'b0;
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
